[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define PBENC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// clocked assertion that a condition never holds outside reset
`define PBENC_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

[sv/pbenc_pkg.sv]
// types and constants of the protobuf scalar field encoder
package pbenc_pkg;

  // input opcodes
  typedef enum logic [2:0] {
    OP_VARINT  = 3'd0,
    OP_ZIGZAG  = 3'd1,
    OP_FIXED64 = 3'd2,
    OP_FIXED32 = 3'd3,
    OP_LENGTH  = 3'd4,
    OP_RAW     = 3'd5
  } op_e;

  // wire types placed in the low bits of the tag
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_I64    = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_I32    = 3'd5;

  // byte counts of the little-endian payloads
  localparam logic [3:0] LE8_BYTES = 4'd8;
  localparam logic [3:0] LE4_BYTES = 4'd4;

  // payload forms carried out by the back end
  typedef enum logic [1:0] {
    KIND_VARINT = 2'd0,
    KIND_LE8    = 2'd1,
    KIND_LE4    = 2'd2,
    KIND_RAW    = 2'd3
  } kind_e;

  // input item
  typedef struct packed {
    logic [2:0]  opcode;
    logic [28:0] field_number;
    logic [63:0] value;
  } pbenc_in_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } pbenc_out_t;

  // classified command between front and back
  typedef struct packed {
    kind_e       kind;
    logic [31:0] tag;
    logic [63:0] payload;
  } cmd_t;

endpackage

[sv/protobuf_scalar_field_encoder_unit.sv]
// An item passes through the command queue, the back end's working registers and
// the output register to the result ports. The serialiser loads each command in its
// idle state, then emits one byte per cycle while the output register is free.
// A queue of QueueDepth commands lets the front keep taking items meanwhile.
// Reset (asynchronous, active low) empties the queue and the result register.
module protobuf_scalar_field_encoder_unit #(
  parameter int QueueDepth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbenc_pkg::pbenc_in_t  in_i,
  input  logic                  push,
  output logic                  full,
  output pbenc_pkg::pbenc_out_t out_o,
  output logic                  empty,
  input  logic                  pop
);

  pbenc_pkg::cmd_t front_cmd, queue_cmd;
  logic            cmd_push, cmd_full, cmd_pop, cmd_empty;

  // classify incoming items
  pbenc_front u_front (
    .in_i       (in_i),
    .push_i     (push),
    .full_o     (full),
    .cmd_o      (front_cmd),
    .cmd_push_o (cmd_push),
    .cmd_full_i (cmd_full)
  );

  // decouple front from back
  pbenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (queue_cmd),
    .empty_o (cmd_empty)
  );

  // byte serialiser with output register
  pbenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_o       (out_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

[sv/pbenc_front.sv]
// front end: accepts items, builds the tag and the payload word
module pbenc_front (
  input  pbenc_pkg::pbenc_in_t in_i,
  input  logic                 push_i,
  output logic                 full_o,
  output pbenc_pkg::cmd_t      cmd_o,
  output logic                 cmd_push_o,
  input  logic                 cmd_full_i
);

  logic       known;
  logic [2:0] wire_type;

  // classify the opcode
  always_comb begin
    known         = 1'b1;
    wire_type     = pbenc_pkg::WIRE_VARINT;
    cmd_o.kind    = pbenc_pkg::KIND_VARINT;
    cmd_o.payload = in_i.value;
    case (in_i.opcode)
      pbenc_pkg::OP_VARINT: begin
        wire_type = pbenc_pkg::WIRE_VARINT;
      end
      pbenc_pkg::OP_ZIGZAG: begin
        wire_type     = pbenc_pkg::WIRE_VARINT;
        cmd_o.payload = {in_i.value[62:0], 1'b0} ^ {64{in_i.value[63]}};
      end
      pbenc_pkg::OP_FIXED64: begin
        wire_type  = pbenc_pkg::WIRE_I64;
        cmd_o.kind = pbenc_pkg::KIND_LE8;
      end
      pbenc_pkg::OP_FIXED32: begin
        wire_type  = pbenc_pkg::WIRE_I32;
        cmd_o.kind = pbenc_pkg::KIND_LE4;
      end
      pbenc_pkg::OP_LENGTH: begin
        wire_type = pbenc_pkg::WIRE_LEN;
      end
      pbenc_pkg::OP_RAW: begin
        cmd_o.kind = pbenc_pkg::KIND_RAW;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    cmd_o.tag = {in_i.field_number, wire_type};
  end

  // unused opcodes are taken and dropped, they give no bytes
  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i && known;

endmodule

[sv/pbenc_queue.sv]
// short command queue between front and back end
module pbenc_queue #(
  parameter int Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pbenc_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output pbenc_pkg::cmd_t data_o,
  output logic            empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pbenc_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/pbenc_back.sv]
// back end: serialises tag (skipped for raw) and payload one byte per cycle while the output slot is free
module pbenc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbenc_pkg::cmd_t       cmd_i,
  input  logic                  cmd_empty_i,
  output logic                  cmd_pop_o,
  output pbenc_pkg::pbenc_out_t out_o,
  output logic                  empty_o,
  input  logic                  pop_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TAG  = 3'b010,
    ST_BODY = 3'b100
  } st_e;

  st_e                   state_q, state_d;
  pbenc_pkg::kind_e      kind_q, kind_d;
  logic [31:0]           tag_q, tag_d;
  logic [63:0]           data_q, data_d;
  logic [3:0]            cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  pbenc_pkg::pbenc_out_t out_q, out_d;
  logic                  slot_free, tag_more, data_more;

  // output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_q || pop_i;
  assign tag_more  = |tag_q[31:7];
  assign data_more = |data_q[63:7];

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    tag_d       = tag_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    cmd_pop_o   = 1'b0;
    case (state_q)
      // load the next command
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          kind_d    = cmd_i.kind;
          tag_d     = cmd_i.tag;
          data_d    = cmd_i.payload;
          cnt_d     = (cmd_i.kind == pbenc_pkg::KIND_LE8) ? pbenc_pkg::LE8_BYTES
                                                         : pbenc_pkg::LE4_BYTES;
          state_d   = (cmd_i.kind == pbenc_pkg::KIND_RAW) ? ST_BODY : ST_TAG;
        end
      end
      // tag varint, never the final byte
      ST_TAG: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.out_byte  = {tag_more, tag_q[6:0]};
          out_d.last_byte = 1'b0;
          tag_d           = {7'd0, tag_q[31:7]};
          if (!tag_more) begin
            state_d = ST_BODY;
          end
        end
      end
      // payload bytes
      ST_BODY: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          case (kind_q)
            pbenc_pkg::KIND_VARINT: begin
              out_d.out_byte  = {data_more, data_q[6:0]};
              out_d.last_byte = !data_more;
              data_d          = {7'd0, data_q[63:7]};
            end
            pbenc_pkg::KIND_LE8, pbenc_pkg::KIND_LE4: begin
              out_d.out_byte  = data_q[7:0];
              out_d.last_byte = (cnt_q == 4'd1);
              data_d          = {8'd0, data_q[63:8]};
              cnt_d           = cnt_q - 4'd1;
            end
            default: begin
              out_d.out_byte  = data_q[7:0];
              out_d.last_byte = 1'b1;
            end
          endcase
          if (out_d.last_byte) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    tag_q  <= tag_d;
    data_q <= data_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  assign out_o   = out_q;
  assign empty_o = !out_valid_q;

endmodule

[sv/pbenc_checker.sv]
// port-level checker for the encoder, bound to the top level
`include "assert_macros.svh"

module pbenc_checker #(
  parameter int QueueDepth = 2
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input pbenc_pkg::pbenc_in_t  in_i,
  input logic                  push,
  input logic                  full,
  input pbenc_pkg::pbenc_out_t out_o,
  input logic                  empty,
  input logic                  pop
);

  localparam int CntW = $clog2(QueueDepth + 4);

  logic [CntW-1:0] open_q;
  logic            item_in, item_done;
  logic            raw_go;
  logic [9:0]      raw_exp, raw_out;

  // items that give bytes, and final-byte transfers
  assign item_in   = push && !full && (in_i.opcode <= pbenc_pkg::OP_RAW);
  assign item_done = pop && !empty && out_o.last_byte;

  // raw byte transfer on an idle block and the result it should give
  assign raw_go  = push && !full && in_i.opcode == pbenc_pkg::OP_RAW && open_q == '0;
  assign raw_exp = {2'b11, in_i.value[7:0]};
  assign raw_out = {!empty, out_o.last_byte, out_o.out_byte};

  // count items whose bytes are not all delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (item_in && !item_done) begin
      open_q <= open_q + 1'b1;
    end else if (item_done && !item_in) begin
      open_q <= open_q - 1'b1;
    end
  end

  // a waiting result holds until it is taken
  `PBENC_ASSERT(a_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(out_o))

  // no result without an open item
  `PBENC_NEVER(a_no_invent, clk_i, rst_ni, !empty && open_q == '0)

  // the queue only fills with open items
  `PBENC_NEVER(a_full_open, clk_i, rst_ni, full && open_q == '0)

  // a raw byte on an idle block reaches the result ports via the queue, flagged last
  `PBENC_ASSERT(a_raw_lat, clk_i, rst_ni, raw_go |-> ##3 raw_out == $past(raw_exp, 3))

endmodule

bind protobuf_scalar_field_encoder_unit pbenc_checker #(
  .QueueDepth (QueueDepth)
) u_pbenc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .push   (push),
  .full   (full),
  .out_o  (out_o),
  .empty  (empty),
  .pop    (pop)
);
